// ===== sv/mtep_pkg.sv =====
// Package for the track event parser: widths, codes, phase and kind enums,
// and the structs passed between the parser blocks. No dependencies.
package mtep_pkg;

  localparam int unsigned TRACK_COUNT = 16;
  localparam int unsigned TRACK_W     = 4;
  localparam logic [TRACK_W:0] TRACK_LIMIT = (TRACK_W + 1)'(TRACK_COUNT);

  localparam logic [7:0] RS_RESET          = 8'h0F;
  localparam logic [7:0] STATUS_META       = 8'hFF;
  localparam logic [7:0] META_END_OF_TRACK = 8'h2F;
  localparam logic [7:0] CHANNEL_NONE      = 8'hFF;

  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_NOTE_ON    = 4'h9;
  localparam logic [3:0] HI_AFTERTOUCH = 4'hA;
  localparam logic [3:0] HI_CONTROL    = 4'hB;
  localparam logic [3:0] HI_PROGRAM    = 4'hC;
  localparam logic [3:0] HI_PRESSURE   = 4'hD;
  localparam logic [3:0] HI_BEND       = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  typedef enum logic [2:0] {
    PH_DELTA,
    PH_STATUS,
    PH_D1,
    PH_D2,
    PH_ONE,
    PH_MTYPE,
    PH_LEN,
    PH_PAYLOAD
  } phase_e;

  typedef enum logic [1:0] {
    KIND_HEADER  = 2'd0,
    KIND_PAYLOAD = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ET_OFF      = 4'd0,
    ET_ON       = 4'd1,
    ET_AFTER    = 4'd2,
    ET_CONTROL  = 4'd3,
    ET_PROGRAM  = 4'd4,
    ET_PRESSURE = 4'd5,
    ET_BEND     = 4'd6,
    ET_SYSTEM   = 4'd7,
    ET_META     = 4'd8
  } evt_type_e;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [7:0]         data_byte;
    logic               restart;
  } in_item_t;

  typedef struct packed {
    kind_e              kind;
    logic [31:0]        delta_ticks;
    logic [3:0]         event_type;
    logic [7:0]         channel;
    logic [7:0]         number;
    logic [14:0]        value;
    logic [31:0]        length;
    logic [7:0]         payload_byte;
    logic               last_payload;
    logic               track_ended;
    logic [TRACK_W-1:0] event_track;
  } result_t;

  typedef struct packed {
    logic               clear;
    logic [TRACK_W-1:0] idx;
    logic               rs_we;
    logic [7:0]         rs_data;
    logic               done_set;
  } tt_upd_t;

  typedef struct packed {
    logic [7:0] status;
    logic       done;
  } tt_rd_t;

endpackage

// ===== sv/mtep_byte_if.sv =====
// Input channel: one track byte per transaction with valid/ready.
// Depends on mtep_pkg.
interface mtep_byte_if;
  import mtep_pkg::*;

  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] track;
  logic [7:0]         data_byte;
  logic               restart;

  modport source (output valid, track, data_byte, restart, input ready);
  modport sink   (input valid, track, data_byte, restart, output ready);
endinterface

// ===== sv/mtep_evt_if.sv =====
// Output channel: one parsed result per transaction with valid/ready.
// Depends on mtep_pkg.
interface mtep_evt_if;
  import mtep_pkg::*;

  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [31:0]        delta_ticks;
  logic [3:0]         event_type;
  logic [7:0]         channel;
  logic [7:0]         number;
  logic [14:0]        value;
  logic [31:0]        length;
  logic [7:0]         payload_byte;
  logic               last_payload;
  logic               track_ended;
  logic [TRACK_W-1:0] event_track;

  modport source (output valid, kind, delta_ticks, event_type, channel, number, value,
                  length, payload_byte, last_payload, track_ended, event_track,
                  input ready);
  modport sink   (input valid, kind, delta_ticks, event_type, channel, number, value,
                  length, payload_byte, last_payload, track_ended, event_track,
                  output ready);
endinterface

// ===== sv/mtep_in_stage.sv =====
// Input register: captures one byte transaction and holds it until the
// parse step takes it. Depends on mtep_pkg.
module mtep_in_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mtep_pkg::in_item_t in_item_i,
  input  logic               take_i,
  output logic               item_valid_o,
  output mtep_pkg::in_item_t item_o
);
  import mtep_pkg::*;

  logic     valid_q, valid_d;
  in_item_t item_q;
  logic     load;

  assign in_ready_o = !valid_q || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;
endmodule

// ===== sv/mtep_track_table.sv =====
// Per-track running status and end-of-track flags, read at the current
// byte's track and updated by the parse step. Depends on mtep_pkg.
module mtep_track_table (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [mtep_pkg::TRACK_W-1:0] rd_idx_i,
  output mtep_pkg::tt_rd_t     rd_o,
  input  mtep_pkg::tt_upd_t    upd_i
);
  import mtep_pkg::*;

  logic [7:0]             rs_q [TRACK_COUNT];
  logic [TRACK_COUNT-1:0] done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        rs_q[i] <= RS_RESET;
      end
      done_q <= '0;
    end else begin
      for (int i = 0; i < TRACK_COUNT; i++) begin
        if (upd_i.rs_we && (TRACK_W'(i) == upd_i.idx)) begin
          rs_q[i] <= upd_i.rs_data;
        end else if (upd_i.clear) begin
          rs_q[i] <= RS_RESET;
        end
        if (upd_i.done_set && (TRACK_W'(i) == upd_i.idx)) begin
          done_q[i] <= 1'b1;
        end else if (upd_i.clear) begin
          done_q[i] <= 1'b0;
        end
      end
    end
  end

  assign rd_o.status = rs_q[rd_idx_i];
  assign rd_o.done   = done_q[rd_idx_i];
endmodule

// ===== sv/mtep_parser.sv =====
// Parse step: event state registers, the single-pass byte decode and the
// result register. Depends on mtep_pkg; drives mtep_track_table updates.
module mtep_parser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  mtep_pkg::in_item_t item_i,
  output logic               take_o,
  input  mtep_pkg::tt_rd_t   tt_rd_i,
  output mtep_pkg::tt_upd_t  tt_upd_o,
  output logic               res_valid_o,
  input  logic               res_ready_i,
  output mtep_pkg::result_t  res_o
);
  import mtep_pkg::*;

  phase_e      phase_q, phase_d;
  logic [31:0] delta_q, delta_d;
  logic [7:0]  cur_q, cur_d;
  logic [7:0]  fd_q, fd_d;
  logic [31:0] len_q, len_d;
  logic [31:0] left_q, left_d;
  logic        halted_q, halted_d;
  logic        res_valid_q;
  result_t     res_q;

  logic        fire;
  logic        has_res;
  result_t     res;
  logic [7:0]  b;
  logic [7:0]  rs_t;
  logic        done_t;
  logic [7:0]  status;
  logic        consumed;
  logic        is_err;
  logic        run_body;
  logic        end_evt;
  logic [31:0] lacc_new;
  logic [31:0] left_new;
  logic        in_range;

  assign take_o = !res_valid_q || res_ready_i;
  assign fire   = item_valid_i && take_o;
  assign b      = item_i.data_byte;
  assign in_range = {1'b0, item_i.track} < TRACK_LIMIT;

  always_comb begin
    phase_d  = phase_q;
    delta_d  = delta_q;
    cur_d    = cur_q;
    fd_d     = fd_q;
    len_d    = len_q;
    left_d   = left_q;
    halted_d = halted_q;
    rs_t     = tt_rd_i.status;
    done_t   = tt_rd_i.done;
    if (item_i.restart) begin
      phase_d  = PH_DELTA;
      delta_d  = '0;
      cur_d    = '0;
      fd_d     = '0;
      len_d    = '0;
      left_d   = '0;
      halted_d = 1'b0;
      rs_t     = RS_RESET;
      done_t   = 1'b0;
    end

    res               = '0;
    has_res           = 1'b0;
    tt_upd_o.clear    = fire && item_i.restart;
    tt_upd_o.idx      = item_i.track;
    tt_upd_o.rs_we    = 1'b0;
    tt_upd_o.rs_data  = b;
    tt_upd_o.done_set = 1'b0;
    status   = rs_t;
    consumed = 1'b0;
    is_err   = 1'b0;
    run_body = 1'b0;
    end_evt  = 1'b0;
    lacc_new = {len_d[24:0], b[6:0]};
    left_new = left_d - 32'd1;

    if (fire && !halted_d && in_range) begin
      res.event_track = item_i.track;
      case (phase_d)
        PH_DELTA: begin
          if (!done_t) begin
            delta_d = {delta_d[24:0], b[6:0]};
            if (!b[7]) begin
              phase_d = PH_STATUS;
            end
          end
        end
        PH_STATUS: begin
          consumed = b[7];
          status   = consumed ? b : rs_t;
          tt_upd_o.rs_we = consumed;
          cur_d    = status;
          case (status[7:4])
            HI_NOTE_OFF, HI_NOTE_ON, HI_AFTERTOUCH, HI_CONTROL, HI_BEND: begin
              phase_d = PH_D1;
            end
            HI_PROGRAM, HI_PRESSURE: begin
              phase_d = PH_ONE;
            end
            HI_SYSTEM: begin
              len_d = '0;
              if (status == STATUS_META) begin
                phase_d = PH_MTYPE;
              end else begin
                fd_d    = {4'h0, status[3:0]};
                phase_d = PH_LEN;
              end
            end
            default: begin
              is_err          = 1'b1;
              res.kind        = KIND_ERROR;
              res.delta_ticks = delta_d;
              has_res         = 1'b1;
              halted_d        = 1'b1;
              end_evt         = 1'b1;
            end
          endcase
          run_body = !consumed && !is_err;
        end
        default: begin
          run_body = 1'b1;
        end
      endcase

      lacc_new = {len_d[24:0], b[6:0]};

      if (run_body) begin
        case (phase_d)
          PH_D1: begin
            fd_d    = b;
            phase_d = PH_D2;
          end
          PH_D2: begin
            res.kind        = KIND_HEADER;
            res.delta_ticks = delta_d;
            res.event_type  = {1'b0, cur_d[6:4]};
            res.channel     = {4'h0, cur_d[3:0]};
            has_res         = 1'b1;
            end_evt         = 1'b1;
            if (cur_d[7:4] == HI_BEND) begin
              res.value = {7'h00, fd_d} | {b, 7'h00};
            end else begin
              res.number = fd_d;
              res.value  = {7'h00, b};
            end
          end
          PH_ONE: begin
            res.kind        = KIND_HEADER;
            res.delta_ticks = delta_d;
            res.event_type  = {1'b0, cur_d[6:4]};
            res.channel     = {4'h0, cur_d[3:0]};
            res.value       = {7'h00, b};
            has_res         = 1'b1;
            end_evt         = 1'b1;
          end
          PH_MTYPE: begin
            fd_d    = b;
            phase_d = PH_LEN;
            tt_upd_o.done_set = (b == META_END_OF_TRACK);
          end
          PH_LEN: begin
            len_d = lacc_new;
            if (!b[7]) begin
              res.kind        = KIND_HEADER;
              res.delta_ticks = delta_d;
              res.event_type  = (cur_d == STATUS_META) ? ET_META : ET_SYSTEM;
              res.channel     = CHANNEL_NONE;
              res.number      = fd_d;
              res.length      = lacc_new;
              res.track_ended = (cur_d == STATUS_META) && (fd_d == META_END_OF_TRACK);
              has_res         = 1'b1;
              if (lacc_new == '0) begin
                end_evt = 1'b1;
              end else begin
                left_d  = lacc_new;
                phase_d = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = b;
            has_res          = 1'b1;
            left_d           = left_new;
            if (left_new == '0) begin
              res.last_payload = 1'b1;
              end_evt          = 1'b1;
            end
          end
          default: begin
            end_evt = 1'b1;
          end
        endcase
      end
    end

    if (end_evt) begin
      phase_d = PH_DELTA;
      delta_d = '0;
      len_d   = '0;
      left_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DELTA;
      delta_q     <= '0;
      cur_q       <= '0;
      fd_q        <= '0;
      len_q       <= '0;
      left_q      <= '0;
      halted_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q  <= phase_d;
        delta_q  <= delta_d;
        cur_q    <= cur_d;
        fd_q     <= fd_d;
        len_q    <= len_d;
        left_q   <= left_d;
        halted_q <= halted_d;
      end
      if (take_o) begin
        res_valid_q <= fire && has_res;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && has_res) begin
      res_q <= res;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;
endmodule

// ===== sv/midi_track_event_parser_core.sv =====
// Top level of the track event parser: input register, track table, parse
// step and result register. Depends on mtep_pkg, mtep_byte_if, mtep_evt_if.
//
//   channel  | dir | carries
//   ---------+-----+-----------------------------------------------------
//   byte_i   | in  | track, data_byte, restart
//   evt_o    | out | kind, delta_ticks, event_type, channel, number, value,
//            |     | length, payload_byte, last_payload, track_ended,
//            |     | event_track
//
// One byte per cycle sustained unless evt_o stalls; a result is offered once its byte
// has passed from the input register through the decode into the result register.
// Bytes that give no result still pass through the decode stage.
// While evt_o stalls, one further byte is held in the input register.
// Reset clears the event state, sets every running status to 0x0F and
// clears the end-of-track flags; the block is ready straight out of reset.
module midi_track_event_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  mtep_byte_if.sink  byte_i,
  mtep_evt_if.source evt_o
);
  import mtep_pkg::*;

  in_item_t in_item;
  in_item_t item;
  logic     item_valid;
  logic     take;
  tt_rd_t   tt_rd;
  tt_upd_t  tt_upd;
  logic     res_valid;
  result_t  res;

  assign in_item.track     = byte_i.track;
  assign in_item.data_byte = byte_i.data_byte;
  assign in_item.restart   = byte_i.restart;

  mtep_in_stage u_in_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (byte_i.valid),
    .in_ready_o   (byte_i.ready),
    .in_item_i    (in_item),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  mtep_track_table u_track_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_idx_i (item.track),
    .rd_o     (tt_rd),
    .upd_i    (tt_upd)
  );

  mtep_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .tt_rd_i      (tt_rd),
    .tt_upd_o     (tt_upd),
    .res_valid_o  (res_valid),
    .res_ready_i  (evt_o.ready),
    .res_o        (res)
  );

  assign evt_o.valid        = res_valid;
  assign evt_o.kind         = res.kind;
  assign evt_o.delta_ticks  = res.delta_ticks;
  assign evt_o.event_type   = res.event_type;
  assign evt_o.channel      = res.channel;
  assign evt_o.number       = res.number;
  assign evt_o.value        = res.value;
  assign evt_o.length       = res.length;
  assign evt_o.payload_byte = res.payload_byte;
  assign evt_o.last_payload = res.last_payload;
  assign evt_o.track_ended  = res.track_ended;
  assign evt_o.event_track  = res.event_track;
endmodule
